/* design/dph_pkg.sv */
`default_nettype none

package dph_pkg;

    // Fixed widths of the transfer fields and configuration registers.
    localparam int COORD_BITS = 24;
    localparam int CMD_W      = 2;
    localparam int COUNT_W    = 21;
    localparam int BIN_W      = 6;
    localparam int NP_W       = 11;
    localparam int NB_W       = 7;
    localparam int MD_W       = 26;

    // Configuration port.
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_BINS   = 64;

    // Register values after reset.
    localparam logic [NP_W-1:0] NUM_POINTS_RST   = 11'd1024;
    localparam logic [NB_W-1:0] BIN_COUNT_RST    = 7'd64;
    localparam logic [MD_W-1:0] MAX_DISTANCE_RST = 26'd1048576;

    typedef enum logic [1:0] {
        REG_NUM_POINTS   = 2'd0,
        REG_BIN_COUNT    = 2'd1,
        REG_MAX_DISTANCE = 2'd2
    } reg_index_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_DATA = 2'd0,
        CMD_LOAD_RAND = 2'd1,
        CMD_COMPUTE   = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PAIRS,
        ST_DRAIN,
        ST_REP_READ,
        ST_REP_LOAD,
        ST_REP_SEND
    } state_t;

    typedef enum logic [1:0] {
        PASS_DD,
        PASS_RR,
        PASS_DR
    } pass_t;

    typedef struct packed {
        logic [CMD_W-1:0]             command;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } item_t;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic [COUNT_W-1:0] data_data_count;
        logic [COUNT_W-1:0] rand_rand_count;
        logic [COUNT_W-1:0] data_rand_count;
        logic               last_bin;
    } result_t;

endpackage

`default_nettype wire

/* design/pair_distance_histogram.sv */
// One point transfer is accepted every cycle while the block is idle. A compute
// clears the histogram, then runs n*(n-1)+n*n pairs of its n points at one pair
// per cycle, set by the two read ports of each point memory, then drains the
// pipeline and then reports the histogram bin by bin.
// Reset restores the register defaults and zeroes both load indices; the
// histograms are cleared at each compute and the point memories are not reset.
`default_nettype none

module pair_distance_histogram
#(
    parameter int MAX_POINTS = dph_pkg::DEF_MAX_POINTS,
    parameter int MAX_BINS   = dph_pkg::DEF_MAX_BINS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  dph_pkg::item_t              item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output dph_pkg::result_t            result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dph_pkg::ADDR_W-1:0]  paddr,
    input  logic [dph_pkg::DATA_W-1:0]  pwdata,
    output logic [dph_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import dph_pkg::*;

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int NW     = $clog2(MAX_POINTS + 1);
    localparam int HAW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CLR_W  = $clog2(MAX_BINS + 2);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int ABS_W  = COORD_BITS;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int D2_W   = SQ_W + 2;
    localparam int NB2_W  = 2 * NB_W;
    localparam int RHS_W  = D2_W + NB2_W;
    localparam int PROD_W = MD_W + NB_W;
    localparam int THR_W  = 2 * PROD_W;
    localparam int CMP_W  = (RHS_W > THR_W) ? RHS_W : THR_W;
    localparam int GROUPS = (MAX_BINS + 7) / 8;
    localparam int GC_W   = 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        logic [COUNT_W-1:0] dd;
        logic [COUNT_W-1:0] rr;
        logic [COUNT_W-1:0] dr;
    } hist_entry_t;

    // Configuration registers.
    logic [NP_W-1:0] num_points_reg;
    logic [NB_W-1:0] bin_count_reg;
    logic [MD_W-1:0] max_distance_reg;
    logic            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg   <= NUM_POINTS_RST;
            bin_count_reg    <= BIN_COUNT_RST;
            max_distance_reg <= MAX_DISTANCE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[ADDR_W-1:2])
                REG_NUM_POINTS:   num_points_reg   <= pwdata[NP_W-1:0];
                REG_BIN_COUNT:    bin_count_reg    <= pwdata[NB_W-1:0];
                REG_MAX_DISTANCE: max_distance_reg <= pwdata[MD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_NUM_POINTS:   prdata = DATA_W'(num_points_reg);
            REG_BIN_COUNT:    prdata = DATA_W'(bin_count_reg);
            REG_MAX_DISTANCE: prdata = DATA_W'(max_distance_reg);
            default:          prdata = '0;
        endcase
    end

    // Control state.
    state_t           state_reg, state_next;
    pass_t            pass_reg;
    logic [AW-1:0]    i_reg, j_reg, n_m1_reg, n_m2_reg;
    logic [NW-1:0]    n_reg;
    logic [NB_W-1:0]  nb_reg, rep_reg;
    logic [NB2_W-1:0] nb2_reg;
    logic [CLR_W-1:0] clr_reg;
    logic [AW-1:0]    data_idx_reg, rand_idx_reg;
    logic             item_accept, pair_last, pipe_empty, clr_done;
    logic [NW-1:0]    n_sat;
    logic [NB_W-1:0]  nb_sat;

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid & ~item_stall;
    assign clr_done    = (clr_reg == CLR_W'(MAX_BINS + 1));
    assign pair_last   = (j_reg == n_m1_reg) &&
                         ((pass_reg == PASS_DR) ? (i_reg == n_m1_reg) : (i_reg == n_m2_reg));

    // Saturated point and bin counts for a new compute.
    always_comb
    begin
        n_sat = (int'(num_points_reg) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points_reg);
        if (bin_count_reg == '0)
            nb_sat = NB_W'(1);
        else if (int'(bin_count_reg) > MAX_BINS)
            nb_sat = NB_W'(MAX_BINS);
        else
            nb_sat = bin_count_reg;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && (item.command == CMD_COMPUTE))
                    state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (clr_done)
                    state_next = (n_reg != '0) ? ST_PAIRS : ST_DRAIN;
            end
            ST_PAIRS:
            begin
                if (pair_last && (pass_reg == PASS_DR))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                    state_next = ST_REP_READ;
            end
            ST_REP_READ: state_next = ST_REP_LOAD;
            ST_REP_LOAD: state_next = ST_REP_SEND;
            ST_REP_SEND:
            begin
                if (!result_stall)
                    state_next = result.last_bin ? ST_IDLE : ST_REP_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Loop counters, load indices and per-compute settings.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg     <= PASS_DD;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            n_m1_reg     <= '0;
            n_m2_reg     <= '0;
            nb_reg       <= NB_W'(1);
            nb2_reg      <= '0;
            clr_reg      <= '0;
            rep_reg      <= '0;
            data_idx_reg <= '0;
            rand_idx_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_accept)
                    begin
                        if (item.command == CMD_LOAD_DATA)
                            data_idx_reg <= (data_idx_reg == AW'(MAX_POINTS - 1)) ?
                                            '0 : data_idx_reg + AW'(1);
                        else if (item.command == CMD_LOAD_RAND)
                            rand_idx_reg <= (rand_idx_reg == AW'(MAX_POINTS - 1)) ?
                                            '0 : rand_idx_reg + AW'(1);
                        else if (item.command == CMD_COMPUTE)
                        begin
                            n_reg        <= n_sat;
                            nb_reg       <= nb_sat;
                            clr_reg      <= '0;
                            data_idx_reg <= '0;
                            rand_idx_reg <= '0;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    clr_reg  <= clr_reg + CLR_W'(1);
                    nb2_reg  <= NB2_W'(nb_reg * nb_reg);
                    n_m1_reg <= AW'(n_reg - NW'(1));
                    n_m2_reg <= AW'(n_reg - NW'(2));
                    i_reg    <= '0;
                    if (n_reg >= NW'(2))
                    begin
                        pass_reg <= PASS_DD;
                        j_reg    <= AW'(1);
                    end
                    else
                    begin
                        pass_reg <= PASS_DR;
                        j_reg    <= '0;
                    end
                end
                ST_PAIRS:
                begin
                    if (j_reg != n_m1_reg)
                        j_reg <= j_reg + AW'(1);
                    else if (pass_reg == PASS_DR)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + AW'(1);
                    end
                    else if (i_reg == n_m2_reg)
                    begin
                        // One triangle finished: start the next pass.
                        i_reg    <= '0;
                        if (pass_reg == PASS_DD)
                        begin
                            pass_reg <= PASS_RR;
                            j_reg    <= AW'(1);
                        end
                        else
                        begin
                            pass_reg <= PASS_DR;
                            j_reg    <= '0;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + AW'(1);
                        j_reg <= i_reg + AW'(2);
                    end
                end
                ST_DRAIN:    rep_reg <= '0;
                ST_REP_SEND:
                begin
                    if (!result_stall)
                        rep_reg <= rep_reg + NB_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Point memories: one write port, two read ports each.
    point_t data_mem [MAX_POINTS];
    point_t rand_mem [MAX_POINTS];
    point_t da_q, db_q, ra_q, rb_q;
    point_t load_pt;

    assign load_pt = '{x: item.coord_x, y: item.coord_y, z: item.coord_z};

    always_ff @(posedge clk)
    begin
        if (item_accept && (item.command == CMD_LOAD_DATA))
            data_mem[data_idx_reg] <= load_pt;
        da_q <= data_mem[i_reg];
        db_q <= data_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && (item.command == CMD_LOAD_RAND))
            rand_mem[rand_idx_reg] <= load_pt;
        ra_q <= rand_mem[i_reg];
        rb_q <= rand_mem[j_reg];
    end

    // Bin thresholds (b*max_distance)^2, built while the histogram clears.
    logic [THR_W-1:0]  thr_reg [MAX_BINS];
    logic [THR_W-1:0]  limit_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [NB_W-1:0]   tb_reg;
    logic              tv_reg;
    logic [THR_W-1:0]  thr_sq;

    assign thr_sq = THR_W'(prod_reg * prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg <= 1'b0;
        else
            tv_reg <= (state_reg == ST_CLEAR) && (int'(clr_reg) < MAX_BINS);
    end

    always_ff @(posedge clk)
    begin
        tb_reg   <= NB_W'(clr_reg) + NB_W'(1);
        prod_reg <= PROD_W'(NB_W'(clr_reg) + NB_W'(1)) * PROD_W'(max_distance_reg);
        if (tv_reg)
        begin
            thr_reg[HAW'(tb_reg - NB_W'(1))] <= thr_sq;
            if (tb_reg == nb_reg)
                limit_reg <= thr_sq;
        end
    end

    // Pair pipeline valid flags and pass tags.
    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    pass_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg, p8_reg;
    logic  in_limit;

    assign pipe_empty = ~(v1_reg | v2_reg | v3_reg | v4_reg |
                          v5_reg | v6_reg | v7_reg | v8_reg);

    // Payload registers of the pair pipeline.
    logic [ABS_W-1:0]   d_reg  [3];
    logic [SQ_W-1:0]    sq_reg [3];
    logic [D2_W-1:0]    d2_reg;
    logic [RHS_W-1:0]   rhs_reg;
    logic [GROUPS*8-1:0] ge_reg;
    logic [GC_W-1:0]    gc_reg [GROUPS];
    logic [HAW-1:0]     bin8_reg;

    assign in_limit = (CMP_W'(rhs_reg) <= CMP_W'(limit_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (state_reg == ST_PAIRS);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg && in_limit;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // Stage one: pick the two points and take absolute coordinate differences.
    point_t            pp, pq;
    logic [ABS_W-1:0]  d_next [3];
    logic signed [DIFF_W-1:0] dx, dy, dz;

    always_comb
    begin
        case (p1_reg)
            PASS_DD:
            begin
                pp = da_q;
                pq = db_q;
            end
            PASS_RR:
            begin
                pp = ra_q;
                pq = rb_q;
            end
            default:
            begin
                pp = ra_q;
                pq = db_q;
            end
        endcase
        dx = DIFF_W'(pp.x) - DIFF_W'(pq.x);
        dy = DIFF_W'(pp.y) - DIFF_W'(pq.y);
        dz = DIFF_W'(pp.z) - DIFF_W'(pq.z);
        d_next[0] = dx[DIFF_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
        d_next[1] = dy[DIFF_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
        d_next[2] = dz[DIFF_W-1] ? ABS_W'(-dz) : ABS_W'(dz);
    end

    // Later stages: squares, sum, scaling by the bin count squared, threshold
    // compare, group counts and final bin.
    logic [GROUPS*8-1:0] ge_next;
    logic [GC_W-1:0]     gc_next [GROUPS];
    logic [NB_W-1:0]     bin_sum;

    always_comb
    begin
        ge_next = '0;
        for (int k = 0; k < MAX_BINS; k++)
            ge_next[k] = ((k + 1) < int'(nb_reg)) &&
                         (CMP_W'(rhs_reg) >= CMP_W'(thr_reg[k]));
    end

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            gc_next[g] = '0;
            for (int b = 0; b < 8; b++)
                gc_next[g] = gc_next[g] + GC_W'(ge_reg[g*8 + b]);
        end
        bin_sum = '0;
        for (int g = 0; g < GROUPS; g++)
            bin_sum = bin_sum + NB_W'(gc_reg[g]);
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= pass_reg;
        p2_reg <= p1_reg;
        p3_reg <= p2_reg;
        p4_reg <= p3_reg;
        p5_reg <= p4_reg;
        p6_reg <= p5_reg;
        p7_reg <= p6_reg;
        p8_reg <= p7_reg;
        for (int a = 0; a < 3; a++)
        begin
            d_reg[a]  <= d_next[a];
            sq_reg[a] <= SQ_W'(d_reg[a] * d_reg[a]);
        end
        d2_reg   <= D2_W'(sq_reg[0]) + D2_W'(sq_reg[1]) + D2_W'(sq_reg[2]);
        rhs_reg  <= RHS_W'(d2_reg) * RHS_W'(nb2_reg);
        ge_reg   <= ge_next;
        gc_reg   <= gc_next;
        bin8_reg <= HAW'(bin_sum);
    end

    // Histogram memory: read, add and write back, with forwarding of the
    // entry written in the previous cycle.
    hist_entry_t       hist_mem [MAX_BINS];
    hist_entry_t       hq_reg;
    hist_entry_t       base, upd, hw_data;
    logic [HAW-1:0]    hr_addr, hw_addr;
    logic              hw_en;
    logic              wv_reg;
    logic [HAW-1:0]    wb_reg;
    hist_entry_t       wd_reg;
    logic [COUNT_W-1:0] old_cnt;
    logic [COUNT_W:0]  sum_cnt;
    logic [COUNT_W-1:0] new_cnt;

    always_comb
    begin
        base = (wv_reg && (wb_reg == bin8_reg)) ? wd_reg : hq_reg;
        case (p8_reg)
            PASS_DD: old_cnt = base.dd;
            PASS_RR: old_cnt = base.rr;
            default: old_cnt = base.dr;
        endcase
        sum_cnt = {1'b0, old_cnt} + ((p8_reg == PASS_DR) ? (COUNT_W+1)'(1) : (COUNT_W+1)'(2));
        new_cnt = (sum_cnt > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_cnt[COUNT_W-1:0];
        upd = base;
        case (p8_reg)
            PASS_DD: upd.dd = new_cnt;
            PASS_RR: upd.rr = new_cnt;
            default: upd.dr = new_cnt;
        endcase

        hr_addr = (state_reg == ST_REP_READ) ? HAW'(rep_reg) : HAW'(bin_sum);
        if ((state_reg == ST_CLEAR) && (int'(clr_reg) < MAX_BINS))
        begin
            hw_en   = 1'b1;
            hw_addr = HAW'(clr_reg);
            hw_data = '0;
        end
        else
        begin
            hw_en   = v8_reg;
            hw_addr = bin8_reg;
            hw_data = upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
            hist_mem[hw_addr] <= hw_data;
        hq_reg <= hist_mem[hr_addr];
        wb_reg <= bin8_reg;
        wd_reg <= upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wv_reg <= 1'b0;
        else
            wv_reg <= v8_reg;
    end

    // Output register for the per-bin report.
    logic    result_valid_reg;
    result_t result_reg;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (state_reg == ST_REP_LOAD)
            result_valid_reg <= 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_REP_LOAD)
        begin
            result_reg.bin_index       <= BIN_W'(rep_reg);
            result_reg.data_data_count <= hq_reg.dd;
            result_reg.rand_rand_count <= hq_reg.rr;
            result_reg.data_rand_count <= hq_reg.dr;
            result_reg.last_bin        <= (rep_reg == (nb_reg - NB_W'(1)));
        end
    end

endmodule

`default_nettype wire

/* bench/dph_checker.sv */
`default_nettype none

module dph_checker
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    input  wire logic                         item_stall,
    input  wire dph_pkg::item_t               item,
    input  wire logic                         result_valid,
    input  wire logic                         result_stall,
    input  wire dph_pkg::result_t             result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dph_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dph_pkg::DATA_W-1:0]   pwdata,
    input  wire logic                         pready,
    output int                                errors,
    output int                                pending,
    output int                                bins_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import dph_pkg::*;

    localparam int SET_DEPTH = DEF_MAX_POINTS;
    localparam int BIN_DEPTH = DEF_MAX_BINS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    point_t           data_set [SET_DEPTH];
    point_t           rand_set [SET_DEPTH];
    int unsigned      data_at;
    int unsigned      rand_at;
    logic [NP_W-1:0]  cfg_points;
    logic [NB_W-1:0]  cfg_bins;
    logic [MD_W-1:0]  cfg_reach;
    result_t          expected_bins[$];

    function automatic longint unsigned gap_of(logic signed [COORD_BITS-1:0] a,
                                               logic signed [COORD_BITS-1:0] b);
        longint sa;
        longint sb;
        sa = a;
        sb = b;
        return (sa >= sb) ? longint'(sa - sb) : longint'(sb - sa);
    endfunction

    // Bin of one pair, or -1 when the pair lies beyond the reach. The bin is
    // found exactly on squared values, so no root is ever taken.
    function automatic int pair_bin(point_t p, point_t q, int nb);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned dz;
        logic [127:0]    d2;
        logic [127:0]    rhs;
        logic [127:0]    t;
        int              lo;
        int              hi;
        int              mid;
        dx = gap_of(p.x, q.x);
        dy = gap_of(p.y, q.y);
        dz = gap_of(p.z, q.z);
        d2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
        if (d2 > 128'(cfg_reach) * 128'(cfg_reach))
            return -1;
        rhs = 128'(nb) * 128'(nb) * d2;
        lo = 0;
        hi = nb - 1;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 128'(mid) * 128'(cfg_reach);
            if (t * t <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic int bump(int count, int amount);
        return (count + amount > int'(COUNT_MAX)) ? int'(COUNT_MAX) : count + amount;
    endfunction

    // Work out the whole report of one compute and queue it bin by bin.
    task automatic predict_report();
        int      n;
        int      nb;
        int      b;
        int      dd [BIN_DEPTH];
        int      rr [BIN_DEPTH];
        int      dr [BIN_DEPTH];
        result_t r;
        n  = (cfg_points > SET_DEPTH) ? SET_DEPTH : int'(cfg_points);
        nb = (cfg_bins < 1) ? 1 : ((cfg_bins > BIN_DEPTH) ? BIN_DEPTH : int'(cfg_bins));
        for (int k = 0; k < BIN_DEPTH; k++)
        begin
            dd[k] = 0;
            rr[k] = 0;
            dr[k] = 0;
        end
        for (int i = 0; i + 1 < n; i++)
        begin
            for (int j = i + 1; j < n; j++)
            begin
                b = pair_bin(data_set[i], data_set[j], nb);
                if (b >= 0)
                    dd[b] = bump(dd[b], 2);
                b = pair_bin(rand_set[i], rand_set[j], nb);
                if (b >= 0)
                    rr[b] = bump(rr[b], 2);
            end
        end
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                b = pair_bin(rand_set[i], data_set[j], nb);
                if (b >= 0)
                    dr[b] = bump(dr[b], 1);
            end
        end
        for (int k = 0; k < nb; k++)
        begin
            r.bin_index       = BIN_W'(k);
            r.data_data_count = COUNT_W'(dd[k]);
            r.rand_rand_count = COUNT_W'(rr[k]);
            r.data_rand_count = COUNT_W'(dr[k]);
            r.last_bin        = (k + 1 == nb);
            expected_bins.push_back(r);
        end
        data_at = 0;
        rand_at = 0;
    endtask

    task automatic compare_bin(result_t got);
        result_t want;
        if (expected_bins.size() == 0)
        begin
            $error("unexpected result transfer: bin_index %0d", got.bin_index);
            errors++;
            return;
        end
        want = expected_bins.pop_front();
        bins_seen++;
        if (got.bin_index !== want.bin_index)
        begin
            $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
            errors++;
        end
        if (got.data_data_count !== want.data_data_count)
        begin
            $error("data_data_count: expected %0d, got %0d",
                   want.data_data_count, got.data_data_count);
            errors++;
        end
        if (got.rand_rand_count !== want.rand_rand_count)
        begin
            $error("rand_rand_count: expected %0d, got %0d",
                   want.rand_rand_count, got.rand_rand_count);
            errors++;
        end
        if (got.data_rand_count !== want.data_rand_count)
        begin
            $error("data_rand_count: expected %0d, got %0d",
                   want.data_rand_count, got.data_rand_count);
            errors++;
        end
        if (got.last_bin !== want.last_bin)
        begin
            $error("last_bin: expected %0d, got %0d", want.last_bin, got.last_bin);
            errors++;
        end
    endtask

    // Watch the register port and both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        point_t p;
        if (!rst_n)
        begin
            data_at    = 0;
            rand_at    = 0;
            cfg_points = NUM_POINTS_RST;
            cfg_bins   = BIN_COUNT_RST;
            cfg_reach  = MAX_DISTANCE_RST;
            expected_bins.delete();
            errors     = 0;
            bins_seen  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_NUM_POINTS:   cfg_points = pwdata[NP_W-1:0];
                    REG_BIN_COUNT:    cfg_bins   = pwdata[NB_W-1:0];
                    REG_MAX_DISTANCE: cfg_reach  = pwdata[MD_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                p.x = item.coord_x;
                p.y = item.coord_y;
                p.z = item.coord_z;
                case (command_t'(item.command))
                    CMD_LOAD_DATA:
                    begin
                        data_set[data_at] = p;
                        data_at = (data_at + 1) % SET_DEPTH;
                    end
                    CMD_LOAD_RAND:
                    begin
                        rand_set[rand_at] = p;
                        rand_at = (rand_at + 1) % SET_DEPTH;
                    end
                    CMD_COMPUTE: predict_report();
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
                compare_bin(result);
        end
        pending = expected_bins.size();
    end

endmodule

`default_nettype wire

/* bench/pair_distance_histogram_tb.sv */
`default_nettype none

module pair_distance_histogram_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dph_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int COORD_MAX   = 8388607;
    localparam int COORD_MIN   = -8388608;
    localparam int REACH_MAX   = 67108863;

    // Command code that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    item_t              item;
    logic               result_valid;
    logic               result_stall;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int errors;
    int pending;
    int bins_seen;
    int cycles;
    int items_sent;
    int computes;
    int cur_points;
    bit calm;
    bit hold_req;

    pair_distance_histogram dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    dph_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .errors       (errors),
        .pending      (pending),
        .bins_seen    (bins_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timed out after %0d cycles", cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // The result side stalls at random, holds off for a long stretch once a
    // report has started after a request, and keeps quiet during the calm
    // stretch.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0 && result_valid)
            begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall = 1'b1;
            end
            else if (calm)
                result_stall = 1'b0;
            else
                result_stall = ($urandom_range(0, 99) < 27);
        end
    end

    task automatic reg_write(reg_index_t idx, int unsigned value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(4 * int'(idx));
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // One transfer on the item channel, with a random gap in front of it now and then outside the calm stretch.
    task automatic send_item(logic [CMD_W-1:0] cmd, int x, int y, int z);
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        item_valid   = 1'b1;
        item.command = cmd;
        item.coord_x = x[COORD_BITS-1:0];
        item.coord_y = y[COORD_BITS-1:0];
        item.coord_z = z[COORD_BITS-1:0];
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        item_valid = 1'b0;
        items_sent++;
        if (cmd == CMD_COMPUTE)
            computes++;
    endtask

    // Wait until every queued bin has come back and the block has settled.
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic configure(int n, int nb, int reach);
        drain();
        reg_write(REG_NUM_POINTS, n);
        reg_write(REG_BIN_COUNT, nb);
        reg_write(REG_MAX_DISTANCE, reach);
        cur_points = n;
    endtask

    function automatic int rand_coord(int scale);
        int v;
        v = $urandom_range(0, 2 * scale) - scale;
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v;
    endfunction

    // Load both sets in shuffled order, with repeats and stray unknown
    // commands mixed in, then start the compute.
    task automatic random_phase(int scale);
        int d_left;
        int r_left;
        int px;
        int py;
        int pz;
        logic [CMD_W-1:0] cmd;
        d_left = cur_points;
        r_left = cur_points;
        px = rand_coord(scale);
        py = rand_coord(scale);
        pz = rand_coord(scale);
        while (d_left + r_left > 0)
        begin
            if ($urandom_range(0, 99) < 5)
                send_item(CMD_UNUSED, rand_coord(scale), rand_coord(scale),
                          rand_coord(scale));
            if (r_left == 0 || (d_left > 0 && $urandom_range(0, 1) == 0))
            begin
                cmd = CMD_LOAD_DATA;
                d_left--;
            end
            else
            begin
                cmd = CMD_LOAD_RAND;
                r_left--;
            end
            if ($urandom_range(0, 99) >= 20)
            begin
                px = rand_coord(scale);
                py = rand_coord(scale);
                pz = rand_coord(scale);
            end
            send_item(cmd, px, py, pz);
        end
        send_item(CMD_COMPUTE, rand_coord(scale), rand_coord(scale), rand_coord(scale));
    endtask

    initial
    begin
        int scale;
        int reach;
        int nb;
        int n;
        int phase;
        int rand_items;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        computes   = 0;
        cur_points = 1024;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Distances right on a bin edge and right at the reach.
        configure(2, 5, 10);
        send_item(CMD_LOAD_DATA, 0, 0, 0);
        send_item(CMD_LOAD_DATA, 10, 0, 0);
        send_item(CMD_LOAD_RAND, 2, 0, 0);
        send_item(CMD_LOAD_RAND, 6, 8, 0);
        send_item(CMD_COMPUTE, 0, 0, 0);

        // Coordinate extremes, a single bin and the widest reach.
        configure(2, 1, REACH_MAX);
        send_item(CMD_LOAD_DATA, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(CMD_UNUSED, COORD_MAX, COORD_MIN, -1);
        send_item(CMD_LOAD_DATA, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(CMD_LOAD_RAND, COORD_MAX, COORD_MIN, 0);
        send_item(CMD_LOAD_RAND, -1, -1, -1);
        send_item(CMD_COMPUTE, COORD_MAX, COORD_MAX, COORD_MAX);

        // Zero reach with a zero bin count: only coincident points count.
        configure(3, 0, 0);
        send_item(CMD_LOAD_DATA, 5, 5, 5);
        send_item(CMD_LOAD_DATA, 5, 5, 5);
        send_item(CMD_LOAD_DATA, 7, 5, 5);
        send_item(CMD_LOAD_RAND, 5, 5, 5);
        send_item(CMD_LOAD_RAND, -5, 5, 5);
        send_item(CMD_LOAD_RAND, 7, 5, 5);
        send_item(CMD_COMPUTE, 0, 0, 0);

        // Oversized point count written first, then an empty set with an oversized
        // bin count and a single-point set with the full bin count.
        drain();
        reg_write(REG_NUM_POINTS, 2047);
        configure(0, 127, 100);
        send_item(CMD_COMPUTE, 0, 0, 0);
        configure(1, 64, 1000);
        send_item(CMD_LOAD_DATA, 300, -200, 100);
        send_item(CMD_LOAD_RAND, -300, 200, -100);
        send_item(CMD_COMPUTE, 0, 0, 0);

        // Random phases: mostly small sets, sometimes a new setting.
        rand_items = items_sent;
        phase = 0;
        while (items_sent - rand_items < 300)
        begin
            scale = 1 << $urandom_range(2, 23);
            if (phase == 0 || (phase != 2 && phase != 3 && $urandom_range(0, 2) == 0))
            begin
                n = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 10)
                                                 : $urandom_range(11, 24);
                case ($urandom_range(0, 9))
                    0: nb = 1;
                    1: nb = 64;
                    default: nb = $urandom_range(1, 64);
                endcase
                case ($urandom_range(0, 19))
                    0: reach = 0;
                    1: reach = REACH_MAX;
                    default: reach = $urandom_range(1, 3 * scale);
                endcase
                if (reach > REACH_MAX)
                    reach = REACH_MAX;
                configure(n, nb, reach);
            end
            // Long hold-off on the result side while new loads keep coming.
            if (phase == 2)
                hold_req = 1'b1;
            calm = (phase >= 5 && phase < 9);
            random_phase(scale);
            phase++;
        end
        calm = 1'b0;

        drain();
        repeat (100) @(negedge clk);
        $display("Ran %0d item transfers and %0d computes; %0d bins checked in %0d cycles.",
                 items_sent, computes, bins_seen, cycles);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
